### hdl/ttc_pkg.sv
// Package for the tangent transition classifier.
// Holds the transaction structs, result kind codes, register indexes and arithmetic helpers.
// It has no dependencies; the classifier and its checker use it by scoped names.
package ttc_pkg;

  // One input transaction: two Q16.16 tangents and a Q2.30 surface normal.
  typedef struct packed {
    logic signed [31:0] first_tangent_x;
    logic signed [31:0] first_tangent_y;
    logic signed [31:0] first_tangent_z;
    logic signed [31:0] second_tangent_x;
    logic signed [31:0] second_tangent_y;
    logic signed [31:0] second_tangent_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } ttc_item_t;

  typedef enum logic [1:0] {
    KIND_IN        = 2'd0,
    KIND_OUT       = 2'd1,
    KIND_TOUCH     = 2'd2,
    KIND_UNDECIDED = 2'd3
  } ttc_kind_t;

  // One result transaction.
  typedef struct packed {
    logic      first_is_tangent;
    ttc_kind_t first_kind;
    logic      first_opposite;
    logic      second_is_tangent;
    ttc_kind_t second_kind;
    logic      second_opposite;
  } ttc_result_t;

  localparam int unsigned CFG_INDEX_W = 2;
  typedef logic [CFG_INDEX_W-1:0] ttc_cfg_index_t;

  localparam ttc_cfg_index_t CFG_LENGTH_TOL    = 2'd0;
  localparam ttc_cfg_index_t CFG_ANGULAR_TOL   = 2'd1;
  localparam ttc_cfg_index_t CFG_COPLANAR_BAND = 2'd2;

  localparam logic [31:0] LENGTH_TOL_RESET    = 32'd1;
  localparam logic [31:0] ANGULAR_TOL_RESET   = 32'd1;
  localparam logic [31:0] COPLANAR_BAND_RESET = 32'd429497;

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int unsigned PIPE_LATENCY = 10;

  function automatic logic signed [63:0] mul_s32(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  // Square of a signed word; the value never exceeds 2^62.
  function automatic logic [62:0] sq_s32(input logic signed [31:0] a);
    logic signed [63:0] prod;
    prod = 64'(a) * 64'(a);
    return prod[62:0];
  endfunction

  function automatic logic [63:0] mul_u32(input logic [31:0] a, input logic [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

### hdl/tangent_transition_classifier_top.sv
// Top level of the tangent transition classifier: a ten-stage pipeline and its register file.
// Depends on ttc_pkg for the transaction structs, kind codes and arithmetic helpers.
//
// The classifier takes one transaction in every clock cycle outside reset and returns one
// result for each, with done high, once it has passed every pipeline stage and the output
// register. Results leave in the order the transactions came in, and since the receiver
// cannot stall, nothing in the pipeline ever waits; busy is high only while reset is held.
// The rate is set by the stage of 32 by 32 bit multipliers that every exact wide product
// is cut into, one row of partial products per stage with the adds that combine them in
// the stages after. The three tolerance registers sit on their own write channel, which is
// always ready; their squares are registered from them, so a new value is in force once
// its square has been registered. They are meant to be written while no transaction is in
// flight.

module tangent_transition_classifier_top (
  input  logic                    clk,
  input  logic                    rst,
  // Input transaction channel.
  input  logic                    start,
  output logic                    busy,
  input  ttc_pkg::ttc_item_t      item,
  // Result channel.
  output logic                    done,
  output ttc_pkg::ttc_result_t    result,
  // Configuration write channel.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  ttc_pkg::ttc_cfg_index_t cfg_index,
  input  logic [31:0]             cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers and their registered squares.
  // ---------------------------------------------------------------------------
  logic [31:0] length_tol;
  logic [31:0] angular_tol;
  logic [31:0] coplanar_band;
  logic [63:0] length_tol_sq;
  logic [63:0] angular_tol_sq;
  logic [63:0] coplanar_band_sq;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_tol    <= ttc_pkg::LENGTH_TOL_RESET;
      angular_tol   <= ttc_pkg::ANGULAR_TOL_RESET;
      coplanar_band <= ttc_pkg::COPLANAR_BAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ttc_pkg::CFG_LENGTH_TOL:    length_tol    <= cfg_data;
        ttc_pkg::CFG_ANGULAR_TOL:   angular_tol   <= cfg_data;
        ttc_pkg::CFG_COPLANAR_BAND: coplanar_band <= cfg_data;
        default: ;  // Writes to unused indexes are dropped.
      endcase
    end
  end

  // Squares follow each write; the user must write only when no transaction is in flight.
  always_ff @(posedge clk) begin
    length_tol_sq    <= ttc_pkg::mul_u32(length_tol, length_tol);
    angular_tol_sq   <= ttc_pkg::mul_u32(angular_tol, angular_tol);
    coplanar_band_sq <= ttc_pkg::mul_u32(coplanar_band, coplanar_band);
  end

  // ---------------------------------------------------------------------------
  // Valid bits. Stage k holds its transaction in stage_valid[k-1]; the output register
  // follows stage nine. Payload registers load every cycle and are only trusted when
  // the matching valid bit is set.
  // ---------------------------------------------------------------------------
  logic       accept;
  logic [8:0] stage_valid;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      done        <= 1'b0;
    end else begin
      stage_valid <= {stage_valid[7:0], accept};
      done        <= stage_valid[8];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: every 32 by 32 product of the raw inputs. The cross product p = t2 x t1 is
  // split into its two terms per component; the squared lengths and the dot product
  // terms are formed alongside.
  // ---------------------------------------------------------------------------
  logic signed [63:0] s1_cpa [3];
  logic signed [63:0] s1_cpb [3];
  logic        [62:0] s1_sq1 [3];
  logic        [62:0] s1_sq2 [3];
  logic signed [63:0] s1_dt  [3];
  logic signed [31:0] s1_n   [3];

  always_ff @(posedge clk) begin
    s1_cpa[0] <= ttc_pkg::mul_s32(item.second_tangent_y, item.first_tangent_z);
    s1_cpb[0] <= ttc_pkg::mul_s32(item.second_tangent_z, item.first_tangent_y);
    s1_cpa[1] <= ttc_pkg::mul_s32(item.second_tangent_z, item.first_tangent_x);
    s1_cpb[1] <= ttc_pkg::mul_s32(item.second_tangent_x, item.first_tangent_z);
    s1_cpa[2] <= ttc_pkg::mul_s32(item.second_tangent_x, item.first_tangent_y);
    s1_cpb[2] <= ttc_pkg::mul_s32(item.second_tangent_y, item.first_tangent_x);
    s1_sq1[0] <= ttc_pkg::sq_s32(item.first_tangent_x);
    s1_sq1[1] <= ttc_pkg::sq_s32(item.first_tangent_y);
    s1_sq1[2] <= ttc_pkg::sq_s32(item.first_tangent_z);
    s1_sq2[0] <= ttc_pkg::sq_s32(item.second_tangent_x);
    s1_sq2[1] <= ttc_pkg::sq_s32(item.second_tangent_y);
    s1_sq2[2] <= ttc_pkg::sq_s32(item.second_tangent_z);
    s1_dt[0]  <= ttc_pkg::mul_s32(item.first_tangent_x, item.second_tangent_x);
    s1_dt[1]  <= ttc_pkg::mul_s32(item.first_tangent_y, item.second_tangent_y);
    s1_dt[2]  <= ttc_pkg::mul_s32(item.first_tangent_z, item.second_tangent_z);
    s1_n[0]   <= item.normal_x;
    s1_n[1]   <= item.normal_y;
    s1_n[2]   <= item.normal_z;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cross product components, squared lengths, and the sign of t1.t2.
  // Each component fits 64 bits even when both of its terms sit at the extremes of the range.
  // ---------------------------------------------------------------------------
  logic signed [63:0] s2_p [3];
  logic        [63:0] s2_l1;
  logic        [63:0] s2_l2;
  logic               s2_opp;
  logic signed [31:0] s2_n [3];
  logic signed [65:0] dot_sum;

  assign dot_sum = 66'(s1_dt[0]) + 66'(s1_dt[1]) + 66'(s1_dt[2]);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_p[i] <= s1_cpa[i] - s1_cpb[i];
      s2_n[i] <= s1_n[i];
    end
    s2_l1  <= 64'(s1_sq1[0]) + 64'(s1_sq1[1]) + 64'(s1_sq1[2]);
    s2_l2  <= 64'(s1_sq2[0]) + 64'(s1_sq2[1]) + 64'(s1_sq2[2]);
    s2_opp <= dot_sum[65];
  end

  // ---------------------------------------------------------------------------
  // Stage 3: length tests against the squared tolerance, and sign and magnitude
  // of the cross product and the normal.
  // ---------------------------------------------------------------------------
  logic [63:0] s3_pm  [3];
  logic [31:0] s3_nm  [3];
  logic        s3_neg [3];
  logic [63:0] s3_l1;
  logic [63:0] s3_l2;
  logic        s3_short1;
  logic        s3_short2;
  logic        s3_opp;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_pm[i]  <= ttc_pkg::mag64(s2_p[i]);
      s3_nm[i]  <= ttc_pkg::mag32(s2_n[i]);
      s3_neg[i] <= s2_p[i][63] ^ s2_n[i][31];
    end
    s3_l1     <= s2_l1;
    s3_l2     <= s2_l2;
    s3_short1 <= (s2_l1 <= length_tol_sq);
    s3_short2 <= (s2_l2 <= length_tol_sq);
    s3_opp    <= s2_opp;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: partial products for |p_i|^2, |p_i||n_i| and |t1|^2 |t2|^2.
  // ---------------------------------------------------------------------------
  logic [63:0] s4_psq_hh [3];
  logic [63:0] s4_psq_hl [3];
  logic [63:0] s4_psq_ll [3];
  logic [63:0] s4_pn_hi  [3];
  logic [63:0] s4_pn_lo  [3];
  logic [63:0] s4_ln_hh;
  logic [63:0] s4_ln_hl;
  logic [63:0] s4_ln_lh;
  logic [63:0] s4_ln_ll;
  logic        s4_neg [3];
  logic        s4_short1;
  logic        s4_short2;
  logic        s4_opp;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s4_psq_hh[i] <= ttc_pkg::mul_u32(s3_pm[i][63:32], s3_pm[i][63:32]);
      s4_psq_hl[i] <= ttc_pkg::mul_u32(s3_pm[i][63:32], s3_pm[i][31:0]);
      s4_psq_ll[i] <= ttc_pkg::mul_u32(s3_pm[i][31:0], s3_pm[i][31:0]);
      s4_pn_hi[i]  <= ttc_pkg::mul_u32(s3_pm[i][63:32], s3_nm[i]);
      s4_pn_lo[i]  <= ttc_pkg::mul_u32(s3_pm[i][31:0], s3_nm[i]);
      s4_neg[i]    <= s3_neg[i];
    end
    s4_ln_hh  <= ttc_pkg::mul_u32(s3_l1[63:32], s3_l2[63:32]);
    s4_ln_hl  <= ttc_pkg::mul_u32(s3_l1[63:32], s3_l2[31:0]);
    s4_ln_lh  <= ttc_pkg::mul_u32(s3_l1[31:0], s3_l2[63:32]);
    s4_ln_ll  <= ttc_pkg::mul_u32(s3_l1[31:0], s3_l2[31:0]);
    s4_short1 <= s3_short1;
    s4_short2 <= s3_short2;
    s4_opp    <= s3_opp;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: partial products combined. The cross term of a square counts twice,
  // hence its shift by 33.
  // ---------------------------------------------------------------------------
  logic [127:0] s5_psq [3];
  logic [95:0]  s5_pnm [3];
  logic [127:0] s5_lens;
  logic         s5_neg [3];
  logic         s5_short1;
  logic         s5_short2;
  logic         s5_opp;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s5_psq[i] <= {s4_psq_hh[i], s4_psq_ll[i]} + (128'(s4_psq_hl[i]) << 33);
      s5_pnm[i] <= (96'(s4_pn_hi[i]) << 32) + 96'(s4_pn_lo[i]);
      s5_neg[i] <= s4_neg[i];
    end
    s5_lens   <= {s4_ln_hh, s4_ln_ll} + (128'(s4_ln_hl) << 32) + (128'(s4_ln_lh) << 32);
    s5_short1 <= s4_short1;
    s5_short2 <= s4_short2;
    s5_opp    <= s4_opp;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: |p|^2, the signed mixed product p.n, and the partial products of
  // |t1|^2 |t2|^2 with the squared angular and band tolerances.
  // ---------------------------------------------------------------------------
  logic        [127:0] s6_lhs;
  logic signed [97:0]  s6_pn;
  logic        [63:0]  s6_la [4][2];
  logic        [63:0]  s6_lb [4][2];
  logic                s6_short1;
  logic                s6_short2;
  logic                s6_opp;
  logic signed [97:0]  pn_term [3];
  logic signed [97:0]  pn_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pn_term[i] = s5_neg[i] ? -$signed(98'(s5_pnm[i])) : $signed(98'(s5_pnm[i]));
    end
    pn_sum = pn_term[0] + pn_term[1] + pn_term[2];
  end

  always_ff @(posedge clk) begin
    s6_lhs <= s5_psq[0] + s5_psq[1] + s5_psq[2];
    s6_pn  <= pn_sum;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 2; j++) begin
        s6_la[k][j] <= ttc_pkg::mul_u32(s5_lens[32*k +: 32], angular_tol_sq[32*j +: 32]);
        s6_lb[k][j] <= ttc_pkg::mul_u32(s5_lens[32*k +: 32], coplanar_band_sq[32*j +: 32]);
      end
    end
    s6_short1 <= s5_short1;
    s6_short2 <= s5_short2;
    s6_opp    <= s5_opp;
  end

  // ---------------------------------------------------------------------------
  // Stage 7: magnitude and sign of p.n; the tolerance products summed per limb of
  // the squared tolerance.
  // ---------------------------------------------------------------------------
  logic [95:0]  s7_pmag;
  logic         s7_ppos;
  logic         s7_pnz;
  logic [159:0] s7_ra [2];
  logic [159:0] s7_rb [2];
  logic [127:0] s7_lhs;
  logic         s7_short1;
  logic         s7_short2;
  logic         s7_opp;
  logic [159:0] row_a [2];
  logic [159:0] row_b [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      row_a[j] = '0;
      row_b[j] = '0;
      for (int k = 0; k < 4; k++) begin
        row_a[j] = row_a[j] + (160'(s6_la[k][j]) << (32 * k));
        row_b[j] = row_b[j] + (160'(s6_lb[k][j]) << (32 * k));
      end
    end
  end

  always_ff @(posedge clk) begin
    s7_pmag   <= s6_pn[97] ? 96'(-s6_pn) : s6_pn[95:0];
    s7_ppos   <= !s6_pn[97];
    s7_pnz    <= (s6_pn == '0);
    for (int j = 0; j < 2; j++) begin
      s7_ra[j] <= row_a[j];
      s7_rb[j] <= row_b[j];
    end
    s7_lhs    <= s6_lhs;
    s7_short1 <= s6_short1;
    s7_short2 <= s6_short2;
    s7_opp    <= s6_opp;
  end

  // ---------------------------------------------------------------------------
  // Stage 8: both right-hand sides completed; partial products of (p.n)^2.
  // ---------------------------------------------------------------------------
  logic [191:0] s8_rhs_a;
  logic [191:0] s8_rhs_b;
  logic [63:0]  s8_d [3];
  logic [63:0]  s8_x01;
  logic [63:0]  s8_x02;
  logic [63:0]  s8_x12;
  logic [127:0] s8_lhs;
  logic         s8_ppos;
  logic         s8_pnz;
  logic         s8_short1;
  logic         s8_short2;
  logic         s8_opp;

  always_ff @(posedge clk) begin
    s8_rhs_a <= 192'(s7_ra[0]) + (192'(s7_ra[1]) << 32);
    s8_rhs_b <= 192'(s7_rb[0]) + (192'(s7_rb[1]) << 32);
    for (int i = 0; i < 3; i++) begin
      s8_d[i] <= ttc_pkg::mul_u32(s7_pmag[32*i +: 32], s7_pmag[32*i +: 32]);
    end
    s8_x01    <= ttc_pkg::mul_u32(s7_pmag[31:0], s7_pmag[63:32]);
    s8_x02    <= ttc_pkg::mul_u32(s7_pmag[31:0], s7_pmag[95:64]);
    s8_x12    <= ttc_pkg::mul_u32(s7_pmag[63:32], s7_pmag[95:64]);
    s8_lhs    <= s7_lhs;
    s8_ppos   <= s7_ppos;
    s8_pnz    <= s7_pnz;
    s8_short1 <= s7_short1;
    s8_short2 <= s7_short2;
    s8_opp    <= s7_opp;
  end

  // ---------------------------------------------------------------------------
  // Stage 9: the touch decision and (p.n)^2. |p|^2 scaled by 2^64 is compared
  // against the product, which is the same as comparing |p|^2 with its top 128 bits.
  // ---------------------------------------------------------------------------
  logic [191:0] s9_pnsq;
  logic [191:0] s9_rhs_b;
  logic         s9_touch;
  logic         s9_ppos;
  logic         s9_pnz;
  logic         s9_short1;
  logic         s9_opp;

  always_ff @(posedge clk) begin
    s9_touch  <= s8_short2 || (s8_lhs <= s8_rhs_a[191:64]);
    s9_pnsq   <= {s8_d[2], s8_d[1], s8_d[0]} + (192'(s8_x01) << 33)
                 + (192'(s8_x02) << 65) + (192'(s8_x12) << 97);
    s9_rhs_b  <= s8_rhs_b;
    s9_ppos   <= s8_ppos;
    s9_pnz    <= s8_pnz;
    s9_short1 <= s8_short1;
    s9_opp    <= s8_opp;
  end

  // ---------------------------------------------------------------------------
  // Output register: the band test and the final choice, in order of precedence:
  // a short first tangent, then a touch, then a crossing, else undecided.
  // (p.n)^2 carries 124 fraction bits, so it is scaled by 16 to meet the product's 128.
  // ---------------------------------------------------------------------------
  logic                 crossing;
  ttc_pkg::ttc_result_t result_next;

  assign crossing = !s9_pnz && ({s9_pnsq, 4'b0000} > {4'b0000, s9_rhs_b});

  always_comb begin
    result_next.first_is_tangent  = 1'b1;
    result_next.first_kind        = ttc_pkg::KIND_UNDECIDED;
    result_next.first_opposite    = 1'b0;
    result_next.second_is_tangent = 1'b1;
    result_next.second_kind       = ttc_pkg::KIND_UNDECIDED;
    result_next.second_opposite   = 1'b0;
    if (s9_short1) begin
      // Defaults stand: both undecided and tangent.
    end else if (s9_touch) begin
      result_next.first_kind      = ttc_pkg::KIND_TOUCH;
      result_next.second_kind     = ttc_pkg::KIND_TOUCH;
      result_next.first_opposite  = s9_opp;
      result_next.second_opposite = s9_opp;
    end else if (crossing) begin
      result_next.first_is_tangent  = 1'b0;
      result_next.second_is_tangent = 1'b0;
      if (s9_ppos) begin
        result_next.first_kind  = ttc_pkg::KIND_IN;
        result_next.second_kind = ttc_pkg::KIND_OUT;
      end else begin
        result_next.first_kind  = ttc_pkg::KIND_OUT;
        result_next.second_kind = ttc_pkg::KIND_IN;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

### hdl/ttc_checker.sv
// Port-level checker for the tangent transition classifier, bound to its top level.
// Depends on ttc_pkg for the kind codes and the pipeline latency.
module ttc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input ttc_pkg::ttc_result_t result
);

  // Every accepted transaction yields its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(ttc_pkg::PIPE_LATENCY) done)
    else $error("accepted transaction gave no result after the pipeline latency");

  // No result appears without a transaction accepted one latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, ttc_pkg::PIPE_LATENCY))
    else $error("result strobe without a matching accepted transaction");

  // Crossing results pair in with out, and only they are not tangent.
  a_crossing_pair: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.first_kind == ttc_pkg::KIND_IN) ==
              (result.second_kind == ttc_pkg::KIND_OUT)) &&
             ((result.first_kind == ttc_pkg::KIND_OUT) ==
              (result.second_kind == ttc_pkg::KIND_IN)) &&
             (result.first_is_tangent == result.second_is_tangent) &&
             (result.first_is_tangent == !(result.first_kind == ttc_pkg::KIND_IN ||
                                           result.first_kind == ttc_pkg::KIND_OUT)))
    else $error("inconsistent crossing classification");

  // The opposite flags agree and are set only for a touch.
  a_opposite_touch: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.first_opposite == result.second_opposite) &&
             (!result.first_opposite || (result.first_kind == ttc_pkg::KIND_TOUCH &&
                                         result.second_kind == ttc_pkg::KIND_TOUCH)))
    else $error("opposite flag outside a touch result");

endmodule

bind tangent_transition_classifier_top ttc_checker u_ttc_checker (.*);
